[design/kalman_position_velocity_fuser_defines.svh]
// assertion macros used by the fuser controller (kpv_ctrl)
// expects clk and arst_n in the scope of each use
`ifndef KALMAN_POSITION_VELOCITY_FUSER_DEFINES_SVH
`define KALMAN_POSITION_VELOCITY_FUSER_DEFINES_SVH

// condition implies property in the same cycle
`define KPV_ASSERT_IMPL(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// condition implies property in the next cycle
`define KPV_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[design/kpv_pkg.sv]
// shared types, register codes and the micro-program of the fuser
// no dependencies
package kpv_pkg;

	localparam int WORD_BITS_DEF = 48;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SIGNED_BITS = 48;
	localparam int UNSIGNED_BITS = 47;
	localparam int CFG_DATA_BITS = 48;
	localparam int CFG_IDX_BITS = 3;
	localparam int DIGIT_BITS = 16;
	localparam int REG_DEPTH = 32;
	localparam int SRC_BITS = 6;
	localparam int UCODE_LEN = 85;
	localparam int PC_BITS = 7;

	typedef enum logic [1:0] {
		OPC_PREDICT = 2'd0,
		OPC_UPDATE = 2'd1,
		OPC_RESTART = 2'd2,
		OPC_NONE = 2'd3
	} opcode_t;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_POS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_VEL = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POS_STD = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACC_STD = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_TIME = 3'd4;

	typedef enum logic [2:0] {
		OP_MOV = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_HALF = 3'd5,
		OP_BRZ = 3'd6
	} uop_op_t;

	// register file addresses (msb clear)
	localparam logic [SRC_BITS-1:0] R_POS = 6'd0;
	localparam logic [SRC_BITS-1:0] R_VEL = 6'd1;
	localparam logic [SRC_BITS-1:0] R_P0 = 6'd2;
	localparam logic [SRC_BITS-1:0] R_P1 = 6'd3;
	localparam logic [SRC_BITS-1:0] R_P2 = 6'd4;
	localparam logic [SRC_BITS-1:0] R_P3 = 6'd5;
	localparam logic [SRC_BITS-1:0] R_Q = 6'd6;
	localparam logic [SRC_BITS-1:0] R_RP = 6'd7;
	localparam logic [SRC_BITS-1:0] R_LT = 6'd8;
	localparam logic [SRC_BITS-1:0] R_T0 = 6'd9;
	localparam logic [SRC_BITS-1:0] R_T1 = 6'd10;
	localparam logic [SRC_BITS-1:0] R_T2 = 6'd11;
	localparam logic [SRC_BITS-1:0] R_T3 = 6'd12;
	localparam logic [SRC_BITS-1:0] R_T4 = 6'd13;
	localparam logic [SRC_BITS-1:0] R_T5 = 6'd14;
	localparam logic [SRC_BITS-1:0] R_T6 = 6'd15;
	localparam logic [SRC_BITS-1:0] R_T7 = 6'd16;
	localparam logic [SRC_BITS-1:0] R_T8 = 6'd17;
	localparam logic [SRC_BITS-1:0] R_T9 = 6'd18;
	localparam logic [SRC_BITS-1:0] R_T10 = 6'd19;
	localparam logic [SRC_BITS-1:0] R_T11 = 6'd20;

	// constant, configuration and input sources (msb set)
	localparam logic [SRC_BITS-1:0] SRC_ZERO = 6'd32;
	localparam logic [SRC_BITS-1:0] SRC_ONE = 6'd33;
	localparam logic [SRC_BITS-1:0] SRC_SP = 6'd34;
	localparam logic [SRC_BITS-1:0] SRC_SV = 6'd35;
	localparam logic [SRC_BITS-1:0] SRC_PSD = 6'd36;
	localparam logic [SRC_BITS-1:0] SRC_ASD = 6'd37;
	localparam logic [SRC_BITS-1:0] SRC_ST = 6'd38;
	localparam logic [SRC_BITS-1:0] SRC_ACC = 6'd39;
	localparam logic [SRC_BITS-1:0] SRC_TNOW = 6'd40;
	localparam logic [SRC_BITS-1:0] SRC_ZP = 6'd41;
	localparam logic [SRC_BITS-1:0] SRC_ZV = 6'd42;
	localparam logic [SRC_BITS-1:0] SRC_PE = 6'd43;
	localparam logic [SRC_BITS-1:0] SRC_VE = 6'd44;

	typedef struct packed {
		uop_op_t op;
		logic cond;
		logic [SRC_BITS-1:0] dst;
		logic [SRC_BITS-1:0] a;
		logic [SRC_BITS-1:0] b;
		logic last;
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic issue;
		logic start;
		logic write;
		logic capture;
		logic load_out;
		logic singular;
	} cmd_t;

	typedef struct packed {
		logic a_zero;
		logic unit_done;
	} status_t;

	localparam logic [PC_BITS-1:0] PROG_RESTART = 7'd0;
	localparam logic [PC_BITS-1:0] PROG_PREDICT = 7'd9;
	localparam logic [PC_BITS-1:0] PROG_UPDATE = 7'd30;

	localparam uop_t UCODE [UCODE_LEN] = '{
		// restart
		'{OP_MOV, 1'b0, R_POS, SRC_SP, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_VEL, SRC_SV, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_P0, SRC_ONE, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_P1, SRC_ZERO, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_P2, SRC_ZERO, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_P3, SRC_ONE, SRC_ZERO, 1'b0},
		'{OP_MUL, 1'b0, R_Q, SRC_ASD, SRC_ASD, 1'b0},
		'{OP_MUL, 1'b0, R_RP, SRC_PSD, SRC_PSD, 1'b0},
		'{OP_MOV, 1'b0, R_LT, SRC_ST, SRC_ZERO, 1'b1},
		// predict: t6 dt, t3 half dt squared, t4 m00, t5 m01
		'{OP_SUB, 1'b0, R_T6, SRC_TNOW, R_LT, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_T6, R_T6, 1'b0},
		'{OP_HALF, 1'b0, R_T3, R_T0, SRC_ZERO, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T6, R_P2, 1'b0},
		'{OP_ADD, 1'b0, R_T4, R_P0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T6, R_P3, 1'b0},
		'{OP_ADD, 1'b0, R_T5, R_P1, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T6, R_VEL, 1'b0},
		'{OP_ADD, 1'b0, R_T2, R_POS, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T3, SRC_ACC, 1'b0},
		'{OP_ADD, 1'b0, R_POS, R_T2, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T6, SRC_ACC, 1'b0},
		'{OP_ADD, 1'b0, R_VEL, R_VEL, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T5, R_T6, 1'b0},
		'{OP_ADD, 1'b0, R_T2, R_T4, R_T1, 1'b0},
		'{OP_ADD, 1'b0, R_P0, R_T2, R_Q, 1'b0},
		'{OP_MOV, 1'b0, R_P1, R_T5, SRC_ZERO, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_P3, R_T6, 1'b0},
		'{OP_ADD, 1'b0, R_P2, R_P2, R_T1, 1'b0},
		'{OP_ADD, 1'b0, R_P3, R_P3, R_Q, 1'b0},
		'{OP_MOV, 1'b0, R_LT, SRC_TNOW, SRC_ZERO, 1'b1},
		// update: innovation covariance and determinant
		'{OP_MUL, 1'b1, R_RP, SRC_PE, SRC_PE, 1'b0},
		'{OP_MUL, 1'b0, R_T0, SRC_VE, SRC_VE, 1'b0},
		'{OP_ADD, 1'b0, R_T1, R_P0, R_RP, 1'b0},
		'{OP_ADD, 1'b0, R_T2, R_P3, R_T0, 1'b0},
		'{OP_MUL, 1'b0, R_T3, R_T1, R_T2, 1'b0},
		'{OP_MUL, 1'b0, R_T4, R_P1, R_P2, 1'b0},
		'{OP_SUB, 1'b0, R_T5, R_T3, R_T4, 1'b0},
		'{OP_BRZ, 1'b0, R_T0, R_T5, SRC_ZERO, 1'b0},
		// inverse: t6 i00, t7 i01, t8 i10, t9 i11
		'{OP_DIV, 1'b0, R_T6, R_T2, R_T5, 1'b0},
		'{OP_SUB, 1'b0, R_T3, SRC_ZERO, R_P1, 1'b0},
		'{OP_DIV, 1'b0, R_T7, R_T3, R_T5, 1'b0},
		'{OP_SUB, 1'b0, R_T3, SRC_ZERO, R_P2, 1'b0},
		'{OP_DIV, 1'b0, R_T8, R_T3, R_T5, 1'b0},
		'{OP_DIV, 1'b0, R_T9, R_T1, R_T5, 1'b0},
		// gain: t10 k00, t11 k01, t2 k10, t3 k11
		'{OP_MUL, 1'b0, R_T0, R_P0, R_T6, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_P1, R_T8, 1'b0},
		'{OP_ADD, 1'b0, R_T10, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_P0, R_T7, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_P1, R_T9, 1'b0},
		'{OP_ADD, 1'b0, R_T11, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_P2, R_T6, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_P3, R_T8, 1'b0},
		'{OP_ADD, 1'b0, R_T2, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_P2, R_T7, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_P3, R_T9, 1'b0},
		'{OP_ADD, 1'b0, R_T3, R_T0, R_T1, 1'b0},
		// state correction
		'{OP_SUB, 1'b0, R_T4, SRC_ZP, R_POS, 1'b0},
		'{OP_SUB, 1'b0, R_T5, SRC_ZV, R_VEL, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_T10, R_T4, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T11, R_T5, 1'b0},
		'{OP_ADD, 1'b0, R_T0, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T2, R_T4, 1'b0},
		'{OP_MUL, 1'b0, R_T6, R_T3, R_T5, 1'b0},
		'{OP_ADD, 1'b0, R_T1, R_T1, R_T6, 1'b0},
		'{OP_ADD, 1'b0, R_POS, R_POS, R_T0, 1'b0},
		'{OP_ADD, 1'b0, R_VEL, R_VEL, R_T1, 1'b0},
		// covariance (i - k) p
		'{OP_SUB, 1'b0, R_T4, SRC_ONE, R_T10, 1'b0},
		'{OP_SUB, 1'b0, R_T5, SRC_ZERO, R_T11, 1'b0},
		'{OP_SUB, 1'b0, R_T6, SRC_ZERO, R_T2, 1'b0},
		'{OP_SUB, 1'b0, R_T7, SRC_ONE, R_T3, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_T4, R_P0, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T5, R_P2, 1'b0},
		'{OP_ADD, 1'b0, R_T8, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_T4, R_P1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T5, R_P3, 1'b0},
		'{OP_ADD, 1'b0, R_T9, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_T6, R_P0, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T7, R_P2, 1'b0},
		'{OP_ADD, 1'b0, R_T10, R_T0, R_T1, 1'b0},
		'{OP_MUL, 1'b0, R_T0, R_T6, R_P1, 1'b0},
		'{OP_MUL, 1'b0, R_T1, R_T7, R_P3, 1'b0},
		'{OP_ADD, 1'b0, R_P3, R_T0, R_T1, 1'b0},
		'{OP_MOV, 1'b0, R_P0, R_T8, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_P1, R_T9, SRC_ZERO, 1'b0},
		'{OP_MOV, 1'b0, R_P2, R_T10, SRC_ZERO, 1'b1}
	};

endpackage

[design/kpv_ram.sv]
// generic register file: one write port, two registered read ports
// no dependencies
module kpv_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr_a,
	input logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[design/kpv_mul.sv]
// iterative saturating fixed-point multiplier, one 16-bit digit per cycle
// depends on kpv_pkg
module kpv_mul import kpv_pkg::*; #(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] a,
	input logic [W-1:0] b,
	output logic done,
	output logic [W-1:0] result
);

	localparam int NCH = (W + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int LW = NCH * DIGIT_BITS;
	localparam int CW = $clog2(NCH);
	localparam int FW = W + 1 + LW;

	logic busy_q, fin_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] ua_q, result_q;
	logic [LW-1:0] ub_q, lo_q;
	logic [W:0] acc_q;
	logic [W+DIGIT_BITS-1:0] prod;
	logic [W+DIGIT_BITS:0] sum;
	logic [FW-1:0] full, shifted, limit, mag_sat;
	logic [W-1:0] mag;

	function automatic logic [W-1:0] abs_word(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	// digit product and accumulate
	assign prod = ua_q * ub_q[DIGIT_BITS-1:0];
	assign sum = (W+DIGIT_BITS+1)'(prod) + (W+DIGIT_BITS+1)'(acc_q);

	// shift out fraction, saturate, apply sign
	assign full = {acc_q, lo_q};
	assign shifted = full >> F;
	assign limit = FW'({1'b0, {(W-1){1'b1}}}) + FW'(neg_q);
	assign mag_sat = (shifted > limit) ? limit : shifted;
	assign mag = mag_sat[W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NCH - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q <= abs_word(a);
			ub_q <= LW'(abs_word(b));
			acc_q <= '0;
			lo_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			acc_q <= sum[W+DIGIT_BITS:DIGIT_BITS];
			lo_q <= {sum[DIGIT_BITS-1:0], lo_q[LW-1:DIGIT_BITS]};
			ub_q <= ub_q >> DIGIT_BITS;
		end
		if (fin_q) begin
			result_q <= neg_q ? (~mag + W'(1)) : mag;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[design/kpv_div.sv]
// restoring saturating fixed-point divider, one quotient bit per cycle
// depends on kpv_pkg
module kpv_div import kpv_pkg::*; #(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] a,
	input logic [W-1:0] b,
	output logic done,
	output logic [W-1:0] result
);

	localparam int NW = W + F;
	localparam int CW = $clog2(NW);

	logic busy_q, fin_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q, quo_q, limit, mag_sat;
	logic [W-1:0] d_q, rem_q, result_q, mag;
	logic [W:0] rem_sh, diff;
	logic ge;

	function automatic logic [W-1:0] abs_word(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	// trial subtract
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge = rem_sh >= {1'b0, d_q};
	assign diff = rem_sh - {1'b0, d_q};

	// saturate and apply sign
	assign limit = NW'({1'b0, {(W-1){1'b1}}}) + NW'(neg_q);
	assign mag_sat = (quo_q > limit) ? limit : quo_q;
	assign mag = mag_sat[W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(abs_word(a)) << F;
			d_q <= abs_word(b);
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
			num_q <= num_q << 1;
		end
		if (fin_q) begin
			result_q <= neg_q ? (~mag + W'(1)) : mag;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[design/kpv_datapath.sv]
// datapath: register file, saturating alu, multiplier, divider, operand
// capture, configuration and result registers; depends on kpv_pkg, kpv_ram,
// kpv_mul and kpv_div
module kpv_datapath import kpv_pkg::*; #(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output status_t status,
	input logic signed [SIGNED_BITS-1:0] accel,
	input logic [UNSIGNED_BITS-1:0] time_now,
	input logic signed [SIGNED_BITS-1:0] meas_position,
	input logic signed [SIGNED_BITS-1:0] meas_velocity,
	input logic [UNSIGNED_BITS-1:0] position_error,
	input logic position_error_valid,
	input logic [UNSIGNED_BITS-1:0] velocity_error,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic signed [SIGNED_BITS-1:0] est_position,
	output logic signed [SIGNED_BITS-1:0] est_velocity,
	output logic singular
);

	localparam int AW = $clog2(REG_DEPTH);

	logic [W-1:0] sp_q, sv_q, psd_q, asd_q, st_q;
	logic [W-1:0] acc_q, tnow_q, zp_q, zv_q, pe_q, ve_q;
	logic pev_q;
	logic [W-1:0] pos_q, vel_q, out_pos_q, out_vel_q;
	logic out_sing_q;
	logic [W-1:0] rd_a, rd_b, opa, opb, wdata, mul_res, div_res;
	logic [W-1:0] add_res, sub_res, half_res;
	logic [W:0] add_w, sub_w, half_w;
	logic we, mul_done, div_done;

	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	// field conversion to the word format
	function automatic logic [W-1:0] as_word(input logic [63:0] raw);
		return raw[W-1:0];
	endfunction

	function automatic logic [W-1:0] as_mag(input logic [63:0] raw);
		return {1'b0, raw[W-2:0]};
	endfunction

	// constants, configuration and captured inputs
	function automatic logic [W-1:0] ext_word(input logic [SRC_BITS-1:0] src);
		logic [W-1:0] v;
		case (src)
			SRC_ONE: v = W'(1) << F;
			SRC_SP: v = sp_q;
			SRC_SV: v = sv_q;
			SRC_PSD: v = psd_q;
			SRC_ASD: v = asd_q;
			SRC_ST: v = st_q;
			SRC_ACC: v = acc_q;
			SRC_TNOW: v = tnow_q;
			SRC_ZP: v = zp_q;
			SRC_ZV: v = zv_q;
			SRC_PE: v = pe_q;
			SRC_VE: v = ve_q;
			default: v = '0;
		endcase
		return v;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			sv_q <= '0;
			psd_q <= W'(1) << F;
			asd_q <= W'(1) << F;
			st_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_POS: sp_q <= as_word(64'($unsigned(cfg_data)));
				CFG_START_VEL: sv_q <= as_word(64'($unsigned(cfg_data)));
				CFG_POS_STD: psd_q <= as_mag(64'($unsigned(cfg_data)));
				CFG_ACC_STD: asd_q <= as_mag(64'($unsigned(cfg_data)));
				CFG_START_TIME: st_q <= as_mag(64'($unsigned(cfg_data)));
				default: ;
			endcase
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q <= as_word(64'($unsigned(accel)));
			tnow_q <= as_mag(64'(time_now));
			zp_q <= as_word(64'($unsigned(meas_position)));
			zv_q <= as_word(64'($unsigned(meas_velocity)));
			pe_q <= as_mag(64'(position_error));
			pev_q <= position_error_valid;
			ve_q <= as_mag(64'(velocity_error));
		end
	end

	kpv_ram #(
		.WIDTH(W),
		.DEPTH(REG_DEPTH)
	) u_regs (
		.clk(clk),
		.we(we),
		.waddr(cmd.uop.dst[AW-1:0]),
		.wdata(wdata),
		.re(cmd.issue),
		.raddr_a(cmd.uop.a[AW-1:0]),
		.raddr_b(cmd.uop.b[AW-1:0]),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// operand select
	assign opa = cmd.uop.a[SRC_BITS-1] ? ext_word(cmd.uop.a) : rd_a;
	assign opb = cmd.uop.b[SRC_BITS-1] ? ext_word(cmd.uop.b) : rd_b;

	kpv_mul #(
		.W(W),
		.F(F)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start && cmd.uop.op == OP_MUL),
		.a(opa),
		.b(opb),
		.done(mul_done),
		.result(mul_res)
	);

	kpv_div #(
		.W(W),
		.F(F)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start && cmd.uop.op == OP_DIV),
		.a(opa),
		.b(opb),
		.done(div_done),
		.result(div_res)
	);

	// saturating add, subtract and halving
	assign add_w = {opa[W-1], opa} + {opb[W-1], opb};
	assign sub_w = {opa[W-1], opa} - {opb[W-1], opb};
	assign half_w = {opa[W-1], opa} + (W+1)'(opa[W-1]);
	assign add_res = (add_w[W] != add_w[W-1]) ? (add_w[W] ? WMIN : WMAX) : add_w[W-1:0];
	assign sub_res = (sub_w[W] != sub_w[W-1]) ? (sub_w[W] ? WMIN : WMAX) : sub_w[W-1:0];
	assign half_res = half_w[W:1];

	// write-back select
	always_comb begin
		case (cmd.uop.op)
			OP_ADD: wdata = add_res;
			OP_SUB: wdata = sub_res;
			OP_HALF: wdata = half_res;
			OP_MUL: wdata = mul_res;
			OP_DIV: wdata = div_res;
			default: wdata = opa;
		endcase
	end

	assign we = cmd.write && (!cmd.uop.cond || pev_q);

	// shadow copies of the estimate
	always_ff @(posedge clk) begin
		if (we && cmd.uop.dst == R_POS) begin
			pos_q <= wdata;
		end
		if (we && cmd.uop.dst == R_VEL) begin
			vel_q <= wdata;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pos_q <= pos_q;
			out_vel_q <= vel_q;
			out_sing_q <= cmd.singular;
		end
	end

	assign status.a_zero = (opa == '0);
	assign status.unit_done = mul_done | div_done;
	assign est_position = SIGNED_BITS'(64'(out_pos_q));
	assign est_velocity = SIGNED_BITS'(64'(out_vel_q));
	assign singular = out_sing_q;

endmodule

[design/kpv_ctrl.sv]
// controller: micro-program sequencer and handshake state machine
// depends on kpv_pkg and the assertion macro header
`include "kalman_position_velocity_fuser_defines.svh"

module kpv_ctrl import kpv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	output logic out_valid,
	input logic out_ready,
	output cmd_t cmd,
	input status_t status
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ISSUE = 5'b00010,
		S_EXEC = 5'b00100,
		S_WAIT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [PC_BITS-1:0] pc_q, pc_d;
	logic init_q, init_d, singular_q, singular_d, out_valid_q;
	logic accept, advance;
	uop_t uop;

	assign uop = UCODE[pc_q];
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// one micro-op finished this cycle
	always_comb begin
		case (state_q)
			S_EXEC: advance = !(uop.op == OP_MUL || uop.op == OP_DIV || uop.op == OP_BRZ) ||
				(uop.op == OP_BRZ && !status.a_zero);
			S_WAIT: advance = status.unit_done;
			default: advance = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		init_d = init_q;
		singular_d = singular_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					singular_d = 1'b0;
					state_d = S_ISSUE;
					case (opcode_t'(opcode))
						OPC_PREDICT: pc_d = PROG_PREDICT;
						OPC_UPDATE: pc_d = PROG_UPDATE;
						OPC_RESTART: pc_d = PROG_RESTART;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ISSUE: state_d = S_EXEC;
			S_EXEC: begin
				if (uop.op == OP_MUL || uop.op == OP_DIV) begin
					state_d = S_WAIT;
				end else if (uop.op == OP_BRZ && status.a_zero) begin
					singular_d = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: ;
		endcase
		if (advance) begin
			if (uop.last) begin
				state_d = init_q ? S_IDLE : S_DONE;
				init_d = 1'b0;
			end else begin
				pc_d = pc_q + PC_BITS'(1);
				state_d = S_ISSUE;
			end
		end
	end

	// state registers; reset runs the restart program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ISSUE;
			pc_q <= PROG_RESTART;
			init_q <= 1'b1;
			singular_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			init_q <= init_d;
			singular_q <= singular_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath commands
	assign cmd.uop = uop;
	assign cmd.issue = (state_q == S_ISSUE);
	assign cmd.start = (state_q == S_EXEC) && (uop.op == OP_MUL || uop.op == OP_DIV);
	assign cmd.write = ((state_q == S_EXEC) && !(uop.op == OP_MUL || uop.op == OP_DIV ||
		uop.op == OP_BRZ)) || ((state_q == S_WAIT) && status.unit_done);
	assign cmd.capture = accept;
	assign cmd.load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign cmd.singular = singular_q;

	// checks
	`KPV_ASSERT_IMPL(a_done_in_wait, status.unit_done, state_q == S_WAIT, "unit done outside wait")
	`KPV_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted transaction left idle")
	`KPV_ASSERT_IMPL(a_init_silent, init_q, state_q != S_DONE && !out_valid_q, "result during init")

endmodule

[design/kalman_position_velocity_fuser.sv]
// One-axis two-state Kalman filter (position, velocity) in signed Q32.16 by default.
// Each transaction is predict, update, restart or opcode 3 (no change) and returns one
// estimate; a controller steps a micro-program through a register file, a saturating
// alu, a digit-serial multiplier and a bit-serial divider. An update ends early when
// the innovation covariance is singular; one transaction is in work at a time while
// the previous result waits in the output register. After reset the restart program
// runs before in_ready rises. Configuration writes are always taken.
// depends on kpv_pkg, kpv_ctrl and kpv_datapath
module kalman_position_velocity_fuser import kpv_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic signed [SIGNED_BITS-1:0] accel,
	input logic [UNSIGNED_BITS-1:0] time_now,
	input logic signed [SIGNED_BITS-1:0] meas_position,
	input logic signed [SIGNED_BITS-1:0] meas_velocity,
	input logic [UNSIGNED_BITS-1:0] position_error,
	input logic position_error_valid,
	input logic [UNSIGNED_BITS-1:0] velocity_error,
	output logic out_valid,
	input logic out_ready,
	output logic signed [SIGNED_BITS-1:0] est_position,
	output logic signed [SIGNED_BITS-1:0] est_velocity,
	output logic singular,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data
);

	cmd_t cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	kpv_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.status(status)
	);

	kpv_datapath #(
		.W(WORD_BITS),
		.F(FRAC_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.accel(accel),
		.time_now(time_now),
		.meas_position(meas_position),
		.meas_velocity(meas_velocity),
		.position_error(position_error),
		.position_error_valid(position_error_valid),
		.velocity_error(velocity_error),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.est_position(est_position),
		.est_velocity(est_velocity),
		.singular(singular)
	);

endmodule

[test/tb.sv]
// testbench for kalman_position_velocity_fuser: directed table, then random phases
// a fixed-point predictor of the filter checks every estimate; depends on kpv_pkg
module tb import kpv_pkg::*; ();

	localparam longint WMAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint WMIN = -WMAX - 1;
	localparam longint UMAX = WMAX;
	localparam longint ONE = 65536;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 357;
	localparam int QUIET_ITEMS = 200;

	typedef struct {
		logic [1:0] op;
		longint acc, tn, zp, zv, pe;
		bit pev;
		longint ve;
		bit known;
		longint ep, ev;
		bit es;
	} item_t;

	typedef struct {
		longint p, v;
		bit s;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic signed [SIGNED_BITS-1:0] accel = '0;
	logic [UNSIGNED_BITS-1:0] time_now = '0;
	logic signed [SIGNED_BITS-1:0] meas_position = '0;
	logic signed [SIGNED_BITS-1:0] meas_velocity = '0;
	logic [UNSIGNED_BITS-1:0] position_error = '0;
	logic position_error_valid = 1'b0;
	logic [UNSIGNED_BITS-1:0] velocity_error = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SIGNED_BITS-1:0] est_position;
	logic signed [SIGNED_BITS-1:0] est_velocity;
	logic singular;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	kalman_position_velocity_fuser DUT (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// filter model: configuration and state
	longint start_pos = 0, start_vel = 0, pos_std = ONE, acc_std = ONE, start_t = 0;
	longint pos, vel, cov[4], q_var, r_pos, last_t;

	estimate_t expected_estimates[$];
	int mismatches = 0;
	bit quiet = 1'b0;

	function automatic longint sext48(logic [63:0] v);
		return longint'({{16{v[47]}}, v[47:0]});
	endfunction

	function automatic longint clamp(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic longint sadd(longint a, longint b);
		return clamp(a + b);
	endfunction

	function automatic longint ssub(longint a, longint b);
		return clamp(a - b);
	endfunction

	// saturate a magnitude to the word range and apply the sign
	function automatic longint settle(logic [127:0] m, bit neg);
		logic [127:0] lim;
		lim = 128'(WMAX) + 128'(neg);
		if (m > lim) m = lim;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint fmul(longint a, longint b);
		logic [127:0] ua, ub;
		ua = 128'(a < 0 ? -a : a);
		ub = 128'(b < 0 ? -b : b);
		return settle((ua * ub) >> FRAC_BITS_DEF, (a < 0) != (b < 0));
	endfunction

	function automatic longint fdiv(longint a, longint b);
		logic [127:0] ua, ub;
		ua = 128'(a < 0 ? -a : a);
		ub = 128'(b < 0 ? -b : b);
		return settle((ua << FRAC_BITS_DEF) / ub, (a < 0) != (b < 0));
	endfunction

	function automatic void restart_filter();
		pos = start_pos;
		vel = start_vel;
		cov = '{ONE, 0, 0, ONE};
		q_var = fmul(acc_std, acc_std);
		r_pos = fmul(pos_std, pos_std);
		last_t = start_t;
	endfunction

	function automatic void write_setting(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] d);
		case (idx)
			CFG_START_POS: start_pos = sext48(64'(d));
			CFG_START_VEL: start_vel = sext48(64'(d));
			CFG_POS_STD: pos_std = longint'(d[46:0]);
			CFG_ACC_STD: acc_std = longint'(d[46:0]);
			CFG_START_TIME: start_t = longint'(d[46:0]);
			default: ;
		endcase
	endfunction

	// advance the filter by one item and return its estimate
	function automatic estimate_t step_filter(item_t it);
		estimate_t e;
		longint dt, hd, m00, m01, rv, s00, s11, det, i00, i01, i10, i11;
		longint k00, k01, k10, k11, y0, y1, n0, n1, n2, n3;
		e.s = 1'b0;
		case (opcode_t'(it.op))
			OPC_PREDICT: begin
				dt = ssub(it.tn, last_t);
				hd = fmul(dt, dt) / 2;
				m00 = sadd(cov[0], fmul(dt, cov[2]));
				m01 = sadd(cov[1], fmul(dt, cov[3]));
				pos = sadd(sadd(pos, fmul(dt, vel)), fmul(hd, it.acc));
				vel = sadd(vel, fmul(dt, it.acc));
				cov[0] = sadd(sadd(m00, fmul(m01, dt)), q_var);
				cov[1] = m01;
				cov[2] = sadd(cov[2], fmul(cov[3], dt));
				cov[3] = sadd(cov[3], q_var);
				last_t = it.tn;
			end
			OPC_UPDATE: begin
				if (it.pev) r_pos = fmul(it.pe, it.pe);
				rv = fmul(it.ve, it.ve);
				s00 = sadd(cov[0], r_pos);
				s11 = sadd(cov[3], rv);
				det = ssub(fmul(s00, s11), fmul(cov[1], cov[2]));
				// skipped update on a zero determinant
				if (det == 0) begin
					e.s = 1'b1;
				end else begin
					i00 = fdiv(s11, det);
					i01 = fdiv(ssub(0, cov[1]), det);
					i10 = fdiv(ssub(0, cov[2]), det);
					i11 = fdiv(s00, det);
					k00 = sadd(fmul(cov[0], i00), fmul(cov[1], i10));
					k01 = sadd(fmul(cov[0], i01), fmul(cov[1], i11));
					k10 = sadd(fmul(cov[2], i00), fmul(cov[3], i10));
					k11 = sadd(fmul(cov[2], i01), fmul(cov[3], i11));
					y0 = ssub(it.zp, pos);
					y1 = ssub(it.zv, vel);
					pos = sadd(pos, sadd(fmul(k00, y0), fmul(k01, y1)));
					vel = sadd(vel, sadd(fmul(k10, y0), fmul(k11, y1)));
					k00 = ssub(ONE, k00);
					k01 = ssub(0, k01);
					k10 = ssub(0, k10);
					k11 = ssub(ONE, k11);
					n0 = sadd(fmul(k00, cov[0]), fmul(k01, cov[2]));
					n1 = sadd(fmul(k00, cov[1]), fmul(k01, cov[3]));
					n2 = sadd(fmul(k10, cov[0]), fmul(k11, cov[2]));
					n3 = sadd(fmul(k10, cov[1]), fmul(k11, cov[3]));
					cov = '{n0, n1, n2, n3};
				end
			end
			OPC_RESTART: restart_filter();
			default: ;
		endcase
		e.p = pos;
		e.v = vel;
		return e;
	endfunction

	// random field values, weighted toward moderate magnitudes
	function automatic longint rand_signed();
		case ($urandom_range(0, 9))
			0: return WMAX;
			1: return WMIN;
			2, 3: return sext48({$urandom, $urandom});
			default: return longint'($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	function automatic longint rand_unsigned();
		case ($urandom_range(0, 9))
			0: return UMAX;
			1: return 0;
			2, 3: return longint'({$urandom, $urandom}) & UMAX;
			default: return longint'($urandom_range(0, 3 * ONE));
		endcase
	endfunction

	function automatic item_t make_item(logic [1:0] op, longint acc, longint tn, longint zp,
			longint zv, longint pe, bit pev, longint ve);
		item_t it;
		it = '{op, acc, tn, zp, zv, pe, pev, ve, 1'b0, 0, 0, 1'b0};
		return it;
	endfunction

	function automatic item_t known_item(item_t it, longint ep, longint ev, bit es);
		it.known = 1'b1;
		it.ep = ep;
		it.ev = ev;
		it.es = es;
		return it;
	endfunction

	// mostly predict runs with short steps and updates, some restarts and noise
	function automatic item_t random_item();
		item_t it;
		int r;
		r = $urandom_range(0, 99);
		it = make_item(OPC_PREDICT, rand_signed(), 0, rand_signed(), rand_signed(),
			rand_unsigned(), $urandom_range(0, 1), rand_unsigned());
		if ($urandom_range(0, 3) != 0) begin
			it.zp = sadd(pos, longint'($urandom_range(0, 1 << 20)) - (1 << 19));
			it.zv = sadd(vel, longint'($urandom_range(0, 1 << 18)) - (1 << 17));
		end
		if ($urandom_range(0, 9) == 0) it.tn = longint'({$urandom, $urandom}) & UMAX;
		else it.tn = (last_t + longint'($urandom_range(1, 1 << 17))) & UMAX;
		if (r < 55) it.op = OPC_PREDICT;
		else if (r < 88) it.op = OPC_UPDATE;
		else if (r < 96) it.op = OPC_RESTART;
		else it.op = OPC_NONE;
		return it;
	endfunction

	task automatic wait_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// one input transaction, sometimes with a random gap ahead of it when not quiet
	task automatic send_item(item_t it);
		estimate_t e;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			wait_cycles($urandom_range(1, 18));
		end
		in_valid <= 1'b1;
		opcode <= it.op;
		accel <= it.acc[47:0];
		time_now <= it.tn[46:0];
		meas_position <= it.zp[47:0];
		meas_velocity <= it.zv[47:0];
		position_error <= it.pe[46:0];
		position_error_valid <= it.pev;
		velocity_error <= it.ve[46:0];
		do @(posedge clk); while (!in_ready);
		e = step_filter(it);
		if (it.known) e = '{it.ep, it.ev, it.es};
		expected_estimates.push_back(e);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_estimates.size() != 0) @(negedge clk);
		wait_cycles(8);
	endtask

	// valid stays high across consecutive writes; the caller drops it
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		write_setting(idx, d);
		@(negedge clk);
	endtask

	// receiver: ready bursts and stalls, steady ready once quiet
	initial begin
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_ready <= 1'b1;
				@(negedge clk);
			end else begin
				out_ready <= 1'b1;
				wait_cycles($urandom_range(1, 30));
				out_ready <= 1'b0;
				wait_cycles($urandom_range(1, 18));
			end
		end
	end

	// estimate checker
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_estimates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected estimate p=%0d v=%0d",
					est_position, est_velocity);
			end else begin
				e = expected_estimates.pop_front();
				if (est_position !== e.p[47:0] || est_velocity !== e.v[47:0]
						|| singular !== e.s) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected p=%0d v=%0d s=%0b, got p=%0d v=%0d s=%0b",
							e.p, e.v, e.s, est_position, est_velocity, singular);
				end
			end
		end
	end

	// stimulus
	initial begin
		item_t directed[$];
		item_t it;
		logic [47:0] phase_cfg[5];
		int sent;
		restart_filter();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (!in_ready) @(negedge clk);

		// directed: extremes, every opcode, backward time, singular innovation
		directed.push_back(known_item(make_item(OPC_NONE, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0));
		directed.push_back(known_item(make_item(OPC_RESTART, 5, 5, 5, 5, 5, 1, 5), 0, 0, 0));
		directed.push_back(make_item(OPC_PREDICT, ONE, ONE, 0, 0, 0, 0, 0));
		directed.push_back(make_item(OPC_UPDATE, 0, 0, 2 * ONE, ONE, ONE, 1, ONE));
		directed.push_back(make_item(OPC_PREDICT, WMAX, 2 * ONE, 0, 0, 0, 0, 0));
		directed.push_back(make_item(OPC_PREDICT, WMIN, 3 * ONE, 0, 0, 0, 0, 0));
		directed.push_back(make_item(OPC_UPDATE, 0, 0, WMAX, WMIN, UMAX, 1, 0));
		directed.push_back(make_item(OPC_UPDATE, 0, 0, WMIN, WMAX, 0, 0, UMAX));
		directed.push_back(make_item(OPC_PREDICT, -ONE / 2, ONE, 0, 0, 0, 0, 0));
		directed.push_back(make_item(OPC_UPDATE, 0, 0, ONE, -ONE, 0, 1, 0));
		directed.push_back(make_item(OPC_NONE, WMIN, UMAX, WMAX, WMIN, UMAX, 1, UMAX));
		directed.push_back(known_item(make_item(OPC_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0));
		directed.push_back(known_item(make_item(OPC_PREDICT, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0));
		directed.push_back(known_item(make_item(OPC_PREDICT, 0, UMAX, 0, 0, 0, 0, 0), 0, 0, 0));
		directed.push_back(known_item(make_item(OPC_UPDATE, 0, 0, ONE, ONE, 0, 0, UMAX),
			0, 0, 1));
		directed.push_back(make_item(OPC_UPDATE, 0, 0, WMAX, WMAX, UMAX, 1, UMAX));
		directed.push_back(make_item(OPC_PREDICT, ONE, UMAX - ONE, 0, 0, 0, 0, 0));
		directed.push_back(known_item(make_item(OPC_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0));
		foreach (directed[i]) send_item(directed[i]);
		drain();

		// random phases, each under its own configuration
		sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_cfg = '{48'(WMAX), 48'(WMIN), 48'd0, 48'(UMAX), 48'(UMAX)};
				1: phase_cfg = '{48'(WMIN), 48'(WMAX), 48'(UMAX), 48'd0, 48'd0};
				2: phase_cfg = '{48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
					48'({$urandom, $urandom})};
				3: phase_cfg = '{48'(100 * ONE), 48'(-3 * ONE), 48'(ONE / 4),
					48'(3 * ONE), 48'(ONE)};
				default: phase_cfg = '{48'd0, 48'd0, 48'(ONE), 48'(ONE), 48'd0};
			endcase
			drain();
			write_reg(CFG_START_POS, phase_cfg[0]);
			write_reg(CFG_START_VEL, phase_cfg[1]);
			write_reg(CFG_POS_STD, phase_cfg[2]);
			write_reg(CFG_ACC_STD, phase_cfg[3]);
			write_reg(CFG_START_TIME, phase_cfg[4]);
			if (ph == 2) write_reg(CFG_UNUSED, 48'({$urandom, $urandom}));
			cfg_valid <= 1'b0;
			send_item(make_item(OPC_RESTART, 0, 0, 0, 0, 0, 0, 0));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (sent >= PHASES * ITEMS_PER_PHASE - QUIET_ITEMS) quiet = 1'b1;
				it = random_item();
				send_item(it);
				sent++;
			end
		end
		in_valid <= 1'b0;
		while (expected_estimates.size() != 0) @(negedge clk);
		wait_cycles(600);
		if (mismatches == 0 && expected_estimates.size() == 0)
			$display("PASS kalman_position_velocity_fuser");
		else
			$display("FAIL kalman_position_velocity_fuser");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("FAIL kalman_position_velocity_fuser");
		$finish;
	end

endmodule
